@@ src/itr_pkg.sv @@
// Shared types, constants and the digit-to-ASCII function for the radix converter.
package itr_pkg;

  // Fixed field widths of the channels
  localparam int IN_VALUE_W = 32;
  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 7;
  localparam int DIGIT_W    = 6;

  // Legal radix range
  localparam logic [RADIX_W-1:0] MIN_RADIX = 6'd2;
  localparam logic [RADIX_W-1:0] MAX_RADIX = 6'd36;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'd65;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture a new item
    logic div_step;    // one restoring-division bit
    logic store;       // write remainder, keep quotient
    logic rd_req;      // read one stored digit
    logic emit_sign;   // load '-' into the output register
    logic emit_digit;  // load the read digit into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic radix_ok;    // incoming radix is 2..36
    logic div_last;    // current division step is the last one
    logic conv_done;   // quotient is zero or digit store is full
    logic negative;    // value was signed and negative
    logic rd_last;     // digit being emitted is the least significant
    logic out_free;    // output register can take a beat this cycle
  } sts_t;

  // Digit value to ASCII: 0-9 then A-Z; anything else reads as '0'
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] off;
    logic [CHAR_W-1:0]  ch;
    off = d - 6'd10;
    if (d < 6'd10) begin
      ch = CHAR_ZERO + CHAR_W'(d);
    end else if (d < MAX_RADIX) begin
      ch = CHAR_A + CHAR_W'(off);
    end else begin
      ch = CHAR_ZERO;
    end
    return ch;
  endfunction

endpackage

@@ src/itr_in_if.sv @@
// Input channel: value, signedness and radix with valid/ready.
interface itr_in_if;
  logic                            valid;
  logic                            ready;
  logic [itr_pkg::IN_VALUE_W-1:0]  value_bits;
  logic                            is_signed;
  logic [itr_pkg::RADIX_W-1:0]     radix;

  modport source (output valid, output value_bits, output is_signed, output radix,
                  input ready);
  modport sink   (input valid, input value_bits, input is_signed, input radix,
                  output ready);
endinterface

@@ src/itr_out_if.sv @@
// Result channel: one ASCII character per beat with valid/ready.
interface itr_out_if;
  logic                        valid;
  logic                        ready;
  logic [itr_pkg::CHAR_W-1:0]  char_code;
  logic                        last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

@@ src/itr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module itr_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/itr_dp.sv @@
// Datapath: bit-serial divider, digit store, character mapping and output register.
module itr_dp #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [itr_pkg::IN_VALUE_W-1:0]   in_value_bits,
  input  logic                             in_is_signed,
  input  logic [itr_pkg::RADIX_W-1:0]      in_radix,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [itr_pkg::CHAR_W-1:0]       out_char_code,
  output logic                             out_last_char,
  input  itr_pkg::cmd_t                    cmd,
  output itr_pkg::sts_t                    sts
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);  // digit count
  localparam int AW = $clog2(VALUE_WIDTH);      // digit store address
  localparam int BW = $clog2(VALUE_WIDTH);      // division bit counter

  // Work registers
  logic [VALUE_WIDTH-1:0]          work_r;
  logic [itr_pkg::DIGIT_W-1:0]     rem_r;
  logic [itr_pkg::RADIX_W-1:0]     base_r;
  logic                            neg_r;
  logic [CW-1:0]                   count_r;
  logic [BW-1:0]                   bitcnt_r;
  logic [AW-1:0]                   rd_idx_r;

  // Output register
  logic                            out_valid_r;
  logic [itr_pkg::CHAR_W-1:0]      out_char_r;
  logic                            out_last_r;

  // Input conditioning: low VALUE_WIDTH bits, magnitude of negative signed values
  logic [VALUE_WIDTH-1:0]          in_v;
  logic                            in_neg;
  logic [VALUE_WIDTH-1:0]          in_mag;

  assign in_v   = VALUE_WIDTH'(in_value_bits);
  assign in_neg = in_is_signed & in_v[VALUE_WIDTH-1];
  assign in_mag = in_neg ? (~in_v + 1'b1) : in_v;

  // One restoring-division step
  logic [itr_pkg::DIGIT_W:0]       trial;
  logic [itr_pkg::DIGIT_W:0]       diff;
  logic                            q_bit;
  logic [itr_pkg::DIGIT_W-1:0]     rem_step;

  assign trial    = {rem_r, work_r[VALUE_WIDTH-1]};
  assign diff     = trial - {1'b0, base_r};
  assign q_bit    = (trial >= {1'b0, base_r});
  assign rem_step = q_bit ? diff[itr_pkg::DIGIT_W-1:0] : trial[itr_pkg::DIGIT_W-1:0];

  // Digit store
  logic [itr_pkg::DIGIT_W-1:0]     rd_digit;

  itr_ram #(
    .WIDTH (itr_pkg::DIGIT_W),
    .DEPTH (VALUE_WIDTH)
  ) u_digit_store (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (count_r[AW-1:0]),
    .wdata (rem_r),
    .re    (cmd.rd_req),
    .raddr (rd_idx_r),
    .rdata (rd_digit)
  );

  // Conversion registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work_r   <= in_mag;
      neg_r    <= in_neg;
      base_r   <= in_radix;
      count_r  <= '0;
      rem_r    <= '0;
      bitcnt_r <= BW'(VALUE_WIDTH - 1);
    end else if (cmd.div_step) begin
      work_r   <= {work_r[VALUE_WIDTH-2:0], q_bit};
      rem_r    <= rem_step;
      bitcnt_r <= bitcnt_r - 1'b1;
    end else if (cmd.store) begin
      count_r  <= count_r + 1'b1;
      rem_r    <= '0;
      bitcnt_r <= BW'(VALUE_WIDTH - 1);
      rd_idx_r <= count_r[AW-1:0];
    end else if (cmd.emit_digit) begin
      rd_idx_r <= rd_idx_r - 1'b1;
    end
  end

  // Output register: holds a beat until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char_r <= itr_pkg::CHAR_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char_r <= itr_pkg::digit_char(rd_digit);
      out_last_r <= (rd_idx_r == '0);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;

  // Status back to the controller
  always_comb begin
    sts           = '0;
    sts.radix_ok  = in_radix inside {[itr_pkg::MIN_RADIX:itr_pkg::MAX_RADIX]};
    sts.div_last  = (bitcnt_r == '0);
    sts.conv_done = (work_r == '0) || (count_r == CW'(VALUE_WIDTH - 1));
    sts.negative  = neg_r;
    sts.rd_last   = (rd_idx_r == '0);
    sts.out_free  = !out_valid_r || out_ready;
  end

`ifndef SYNTHESIS
  // A new beat never overwrites one the sink has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_sign || cmd.emit_digit) |-> (!out_valid_r || out_ready))
    else $error("output beat overwritten while stalled");

  // A finished division leaves a remainder below the radix
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> (rem_r < base_r))
    else $error("remainder not below radix");

  // The digit count never passes the store depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |=> (count_r <= CW'(VALUE_WIDTH)))
    else $error("digit count beyond store depth");
`endif

endmodule

@@ src/itr_ctrl.sv @@
// Controller: sequences load, per-digit division, digit store and character output.
module itr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output itr_pkg::cmd_t cmd,
  input  itr_pkg::sts_t sts
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DIV    = 6'b000010,
    S_STORE  = 6'b000100,
    S_SIGN   = 6'b001000,
    S_RDADDR = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && sts.radix_ok) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (sts.conv_done) begin
          state_nxt = sts.negative ? S_SIGN : S_RDADDR;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_SIGN: begin
        if (sts.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = S_RDADDR;
        end
      end
      S_RDADDR: begin
        cmd.rd_req = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          state_nxt      = sts.rd_last ? S_IDLE : S_RDADDR;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  // A digit is stored only after the last division step
  a_store_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STORE) |-> ($past(state_r) == S_DIV && $past(sts.div_last)))
    else $error("digit stored before division finished");

  // An accepted item with a legal radix closes the input until it is done
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && sts.radix_ok) |=> !in_ready)
    else $error("input still open after load");

  // Every digit beat is preceded by its store read
  a_read_before_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_digit |-> ($past(cmd.rd_req) || $past(state_r) == S_EMIT))
    else $error("digit emitted without a store read");
`endif

endmodule

@@ src/integer_to_radix_digits.sv @@
// Sequence: a load, then per digit one quotient bit per cycle in the shared restoring
// divider followed by a store into the digit store, then per character out a digit
// store read and an output load, with a minus sign loaded first for a negative value.
// Throughput: one item at a time; the next is taken once its last character is loaded
// into the output register.
// Reset: synchronous active-low rst_n clears the state machine and the output valid.
module integer_to_radix_digits #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  itr_in_if.sink     in_ch,
  itr_out_if.source  out_ch
);

  itr_pkg::cmd_t cmd;
  itr_pkg::sts_t sts;

  // Sequencer
  itr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Divider, digit store and output register
  itr_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value_bits (in_ch.value_bits),
    .in_is_signed  (in_ch.is_signed),
    .in_radix      (in_ch.radix),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_char_code (out_ch.char_code),
    .out_last_char (out_ch.last_char),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the integer to radix-digit converter.
module tb_top;
  import itr_pkg::*;

  localparam int ITEM_GOAL      = 500;    // input items in all, directed and random
  localparam int HOLD_AT_ITEM   = 40;     // input count that starts the long sink hold
  localparam int HOLD_CYCLES    = 2000;   // outlasts a full radix-2 conversion
  localparam int DRAIN_EVERY    = 97;     // every this many random items, one waits for an empty queue
  localparam int END_PAUSE      = 1200;   // one full radix-2 conversion and then some
  localparam int WATCHDOG_LIMIT = 20000;

  // One conversion request and one character beat
  typedef struct packed {
    logic [IN_VALUE_W-1:0] value_bits;
    logic                  is_signed;
    logic [RADIX_W-1:0]    radix;
  } conv_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } char_beat_t;

  typedef struct packed {
    conv_req_t req;
    logic      drain_first;   // hold this request until every character is back
  } pending_req_t;

  logic clk;
  logic rst_n;

  itr_in_if  in_ch();
  itr_out_if out_ch();

  integer_to_radix_digits #(.VALUE_WIDTH(IN_VALUE_W)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pending_req_t pending_reqs[$];
  char_beat_t   expected_chars[$];

  int total_reqs;
  int reqs_accepted;
  int chars_owed;
  int error_count;
  int hold_left;
  bit hold_done;
  int idle_cycles;

  // Driver and monitor private state
  int  feed_gap;
  int  feed_burst;
  bit  drain_hold;
  int  sink_stall;
  int  sink_burst;

  always #4 clk = ~clk;

  // Expected characters of one request: sign first, then digits most significant first
  function automatic void predict_chars(input conv_req_t req);
    logic [IN_VALUE_W-1:0] mag;
    logic [DIGIT_W-1:0]    digits [IN_VALUE_W];
    logic                  neg;
    int                    n;
    char_beat_t            beat;
    if (req.radix < MIN_RADIX || req.radix > MAX_RADIX) return;
    neg = req.is_signed && req.value_bits[IN_VALUE_W-1];
    // most negative value wraps to its own bit pattern, read as unsigned
    mag = neg ? (IN_VALUE_W'(0) - req.value_bits) : req.value_bits;
    n = 0;
    do begin
      digits[n] = DIGIT_W'(mag % IN_VALUE_W'(req.radix));
      mag = mag / IN_VALUE_W'(req.radix);
      n++;
    end while (mag != 0 && n < IN_VALUE_W);
    if (neg) begin
      beat.char_code = CHAR_MINUS;
      beat.last_char = 1'b0;
      expected_chars.push_back(beat);
    end
    for (int k = n - 1; k >= 0; k--) begin
      if (digits[k] < 10) begin
        beat.char_code = CHAR_ZERO + CHAR_W'(digits[k]);
      end else begin
        beat.char_code = CHAR_A + CHAR_W'(digits[k] - 10);
      end
      beat.last_char = (k == 0);
      expected_chars.push_back(beat);
    end
  endfunction

  task automatic add_req(input logic [IN_VALUE_W-1:0] value_bits, input logic is_signed,
                         input logic [RADIX_W-1:0] radix, input logic drain_first);
    pending_req_t p;
    p.req.value_bits = value_bits;
    p.req.is_signed  = is_signed;
    p.req.radix      = radix;
    p.drain_first    = drain_first;
    pending_reqs.push_back(p);
  endtask

  // Stimulus, reset and end of run
  initial begin
    int drawn;
    logic [IN_VALUE_W-1:0] v;
    logic [RADIX_W-1:0]    r;
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.value_bits = '0;
    in_ch.is_signed  = 1'b0;
    in_ch.radix      = '0;
    out_ch.ready     = 1'b0;

    // directed: zero, extremes, most negative value, alphabet edges, illegal radixes
    add_req(32'h0000_0000, 1'b0, 6'd10, 1'b0);
    add_req(32'h0000_0000, 1'b1, 6'd2,  1'b0);
    add_req(32'h0000_0001, 1'b0, 6'd2,  1'b0);
    add_req(32'hFFFF_FFFF, 1'b0, 6'd2,  1'b0);
    add_req(32'hFFFF_FFFF, 1'b1, 6'd2,  1'b0);
    add_req(32'h8000_0000, 1'b1, 6'd2,  1'b0);
    add_req(32'h8000_0000, 1'b1, 6'd10, 1'b0);
    add_req(32'h8000_0000, 1'b0, 6'd16, 1'b0);
    add_req(32'h7FFF_FFFF, 1'b1, 6'd36, 1'b0);
    add_req(32'hFFFF_FFFF, 1'b0, 6'd36, 1'b0);
    add_req(32'hFFFF_FFFF, 1'b0, 6'd3,  1'b0);
    add_req(32'd35,        1'b0, 6'd36, 1'b0);
    add_req(32'd10,        1'b0, 6'd11, 1'b0);
    add_req(32'h1234_5678, 1'b0, 6'd0,  1'b0);
    add_req(32'h1234_5678, 1'b1, 6'd1,  1'b0);
    add_req(32'hFFFF_FFFF, 1'b1, 6'd37, 1'b0);
    add_req(32'h8000_0000, 1'b0, 6'd63, 1'b0);
    add_req(32'hDEAD_BEEF, 1'b1, 6'd16, 1'b1);
    add_req(32'd12345,     1'b1, 6'd10, 1'b0);
    add_req(32'hFFFF_FF85, 1'b1, 6'd10, 1'b0);
    add_req(32'h2AAA_AAAA, 1'b0, 6'd2,  1'b0);

    // random: mostly legal radixes, value shapes that reach short and long digit strings
    drawn = 0;
    while (pending_reqs.size() < ITEM_GOAL) begin
      case ($urandom_range(0, 5))
        0:       v = $urandom;
        1:       v = $urandom_range(0, 1000);
        2:       v = $urandom >> $urandom_range(0, 31);
        3:       v = IN_VALUE_W'(0) - IN_VALUE_W'($urandom_range(1, 1000));
        4: begin
          case ($urandom_range(0, 4))
            0:       v = 32'h0000_0000;
            1:       v = 32'h0000_0001;
            2:       v = 32'h7FFF_FFFF;
            3:       v = 32'h8000_0000;
            default: v = 32'hFFFF_FFFF;
          endcase
        end
        default: v = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom)};
      endcase
      case ($urandom_range(0, 9))
        0:       r = $urandom_range(0, 1) ? RADIX_W'($urandom_range(0, 1))
                                          : RADIX_W'($urandom_range(37, 63));
        1:       r = MIN_RADIX;
        2:       r = MAX_RADIX;
        3:       r = $urandom_range(0, 1) ? 6'd10 : 6'd16;
        default: r = RADIX_W'($urandom_range(2, 36));
      endcase
      drawn++;
      add_req(v, 1'($urandom_range(0, 1)), r, (drawn % DRAIN_EVERY) == 0);
    end
    total_reqs = pending_reqs.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // all requests taken and all characters back, then let the block settle
    do @(posedge clk); while (reqs_accepted != total_reqs || chars_owed != 0);
    repeat (END_PAUSE) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Driver: one request per beat, random gaps with gapless bursts
  always @(posedge clk) begin : feed_proc
    logic         offer;
    pending_req_t p;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      feed_gap     = 0;
      feed_burst   = 0;
      drain_hold   = 1'b0;
    end else begin
      offer = in_ch.valid && !in_ch.ready;
      if (!offer) begin
        if (drain_hold) begin
          // payload is already on the bus; release once the sink has caught up
          if (chars_owed == 0) begin
            drain_hold = 1'b0;
            offer      = 1'b1;
          end
        end else if (feed_gap != 0) begin
          feed_gap--;
        end else if (pending_reqs.size() != 0) begin
          p = pending_reqs.pop_front();
          in_ch.value_bits <= p.req.value_bits;
          in_ch.is_signed  <= p.req.is_signed;
          in_ch.radix      <= p.req.radix;
          if (p.drain_first) drain_hold = 1'b1;
          else               offer      = 1'b1;
          // gap after this beat
          if (feed_burst != 0) begin
            feed_burst--;
            feed_gap = 0;
          end else begin
            feed_gap = $urandom_range(0, 5);
            if ($urandom_range(0, 15) == 0) feed_burst = $urandom_range(10, 30);
          end
        end
      end
      in_ch.valid <= offer;
    end
  end

  // Long sink hold, counted here, once enough requests have gone in
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && reqs_accepted >= HOLD_AT_ITEM) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: predict on input beats, check output beats, pace ready
  always @(posedge clk) begin : check_proc
    conv_req_t  req;
    char_beat_t want;
    if (!rst_n) begin
      out_ch.ready  <= 1'b0;
      chars_owed    <= 0;
      reqs_accepted <= 0;
      sink_stall     = 0;
      sink_burst     = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        req.value_bits = in_ch.value_bits;
        req.is_signed  = in_ch.is_signed;
        req.radix      = in_ch.radix;
        predict_chars(req);
        reqs_accepted <= reqs_accepted + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected beat: char_code %0d last_char %0b",
                 out_ch.char_code, out_ch.last_char);
          error_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_ch.char_code !== want.char_code) begin
            $error("char_code: expected %0d, got %0d", want.char_code, out_ch.char_code);
            error_count++;
          end
          if (out_ch.last_char !== want.last_char) begin
            $error("last_char: expected %0b, got %0b", want.last_char, out_ch.last_char);
            error_count++;
          end
        end
        // stall after this beat
        if (sink_burst != 0) begin
          sink_burst--;
          sink_stall = 0;
        end else begin
          sink_stall = $urandom_range(0, 5);
          if ($urandom_range(0, 15) == 0) sink_burst = $urandom_range(20, 60);
        end
      end else if (sink_stall != 0) begin
        sink_stall--;
      end
      out_ch.ready <= (sink_stall == 0) && (hold_left == 0);
      chars_owed   <= expected_chars.size();
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
